// File: hdl/obj_lex_pkg.sv
package obj_lex_pkg;

  localparam int FieldW = 24;
  localparam int Slots  = 3;
  localparam int SlotW  = 2;

  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_V     = 8'h76;
  localparam logic [7:0] CHAR_N     = 8'h6E;
  localparam logic [7:0] CHAR_T     = 8'h74;
  localparam logic [7:0] CHAR_P     = 8'h70;
  localparam logic [7:0] CHAR_F     = 8'h66;
  localparam logic [7:0] CHAR_O     = 8'h6F;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WORD = 2'd1,
    MODE_STOP = 2'd2
  } lex_mode_e;

  typedef enum logic [3:0] {
    KIND_V      = 4'd0,
    KIND_VN     = 4'd1,
    KIND_VT     = 4'd2,
    KIND_VP     = 4'd3,
    KIND_F      = 4'd4,
    KIND_O      = 4'd5,
    KIND_NUMBER = 4'd6,
    KIND_IDENT  = 4'd7,
    KIND_SLASH  = 4'd8,
    KIND_ERROR  = 4'd9,
    KIND_END    = 4'd10
  } token_kind_e;

  // Up to three results raised by one byte, slot 0 first
  typedef struct packed {
    logic [SlotW-1:0]             count;
    token_kind_e [Slots-1:0]      kind;
    logic [Slots-1:0][FieldW-1:0] start;
    logic [Slots-1:0][FieldW-1:0] length;
  } bundle_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic token_kind_e lex_classify(logic [7:0] c1, logic [7:0] c2,
                                               logic is1, logic is2, logic gt1);
    token_kind_e k;
    k = KIND_ERROR;
    if (is1 && c1 == CHAR_V) begin
      k = KIND_V;
    end else if (is1 && c1 == CHAR_F) begin
      k = KIND_F;
    end else if (is1 && c1 == CHAR_O) begin
      k = KIND_O;
    end else if (is2 && c1 == CHAR_V && c2 == CHAR_N) begin
      k = KIND_VN;
    end else if (is2 && c1 == CHAR_V && c2 == CHAR_T) begin
      k = KIND_VT;
    end else if (is2 && c1 == CHAR_V && c2 == CHAR_P) begin
      k = KIND_VP;
    end else if (is_digit(c1) || (c1 == CHAR_MINUS && gt1 && is_digit(c2))) begin
      k = KIND_NUMBER;
    end else if (is_letter(c1)) begin
      k = KIND_IDENT;
    end
    return k;
  endfunction

endpackage

// File: hdl/obj_lex_scan.sv
module obj_lex_scan #(
  parameter int OffsetBits = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_byte_i,
  input  logic                in_final_i,
  input  logic                can_load_i,
  output logic                load_o,
  output obj_lex_pkg::bundle_t bundle_o
);
  import obj_lex_pkg::*;

  localparam int WideW = (OffsetBits > FieldW) ? OffsetBits : FieldW;

  function automatic logic [FieldW-1:0] to_field(logic [OffsetBits-1:0] v);
    logic [WideW-1:0] w;
    w = WideW'(v);
    return w[FieldW-1:0];
  endfunction

  // input register
  logic       vld_q;
  logic [7:0] byte_q;
  logic       fin_q;

  // lexer state
  lex_mode_e             mode_q, mode_d;
  logic [OffsetBits-1:0] pos_q, pos_d;
  logic [OffsetBits-1:0] begin_q, begin_d;
  logic [7:0]            c1_q, c1_d;
  logic [7:0]            c2_q, c2_d;

  logic                  fire;
  logic                  in_word, err, delim;
  logic [SlotW-1:0]      n;
  logic [OffsetBits-1:0] len0, len1, pos1;
  token_kind_e           k0, k1;
  bundle_t               bnd;

  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q;
    begin_d = begin_q;
    c1_d    = c1_q;
    c2_d    = c2_q;
    n       = '0;
    err     = 1'b0;
    bnd     = '0;
    in_word = 1'b0;
    delim   = is_space(byte_q) || (byte_q == CHAR_SLASH);
    len0    = pos_q - begin_q;
    pos1    = pos_q + OffsetBits'(1);
    len1    = '0;
    k0      = lex_classify(c1_q, c2_q, len0 == OffsetBits'(1), len0 == OffsetBits'(2),
                           len0 > OffsetBits'(1));
    k1      = KIND_ERROR;

    case (mode_q)
      MODE_STOP: begin
        if (fin_q) begin
          mode_d  = MODE_IDLE;
          pos_d   = '0;
          begin_d = '0;
          c1_d    = '0;
          c2_d    = '0;
        end
      end
      default: begin
        in_word = (mode_q == MODE_WORD);
        // close the open word on a delimiter
        if (in_word && delim) begin
          bnd.kind[n]   = k0;
          bnd.start[n]  = to_field(begin_q);
          bnd.length[n] = to_field(len0);
          n             = n + 1'b1;
          in_word       = 1'b0;
          err           = (k0 == KIND_ERROR);
        end else if (in_word && len0 == OffsetBits'(1)) begin
          c2_d = byte_q;
        end
        if (!err && !in_word) begin
          if (byte_q == CHAR_SLASH) begin
            bnd.kind[n]   = KIND_SLASH;
            bnd.start[n]  = to_field(pos_q);
            bnd.length[n] = FieldW'(1);
            n             = n + 1'b1;
          end else if (!is_space(byte_q)) begin
            in_word = 1'b1;
            begin_d = pos_q;
            c1_d    = byte_q;
            c2_d    = '0;
          end
        end
        pos_d  = pos1;
        mode_d = in_word ? MODE_WORD : MODE_IDLE;
        // close out the file
        if (!err && fin_q) begin
          if (in_word) begin
            len1 = pos1 - begin_d;
            k1   = lex_classify(c1_d, c2_d, len1 == OffsetBits'(1),
                                len1 == OffsetBits'(2), len1 > OffsetBits'(1));
            bnd.kind[n]   = k1;
            bnd.start[n]  = to_field(begin_d);
            bnd.length[n] = to_field(len1);
            n             = n + 1'b1;
            err           = (k1 == KIND_ERROR);
          end
          if (!err) begin
            bnd.kind[n]   = KIND_END;
            bnd.start[n]  = to_field(pos1);
            bnd.length[n] = '0;
            n             = n + 1'b1;
          end
        end
        if (fin_q) begin
          mode_d  = MODE_IDLE;
          pos_d   = '0;
          begin_d = '0;
          c1_d    = '0;
          c2_d    = '0;
        end else if (err) begin
          mode_d = MODE_STOP;
        end
      end
    endcase
    bnd.count = n;
  end

  assign fire       = vld_q && ((n == '0) || can_load_i);
  assign load_o     = fire && (n != '0);
  assign bundle_o   = bnd;
  assign in_ready_o = !vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      begin_q <= '0;
      c1_q    <= '0;
      c2_q    <= '0;
    end else begin
      if (in_ready_o) begin
        vld_q <= in_valid_i;
      end
      if (fire) begin
        mode_q  <= mode_d;
        pos_q   <= pos_d;
        begin_q <= begin_d;
        c1_q    <= c1_d;
        c2_q    <= c2_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
      fin_q  <= in_final_i;
    end
  end

endmodule

// File: hdl/obj_lex_emit.sv
module obj_lex_emit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  obj_lex_pkg::bundle_t bundle_i,
  output logic                 can_load_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [3:0]           out_kind_o,
  output logic [23:0]          out_start_o,
  output logic [23:0]          out_length_o,
  output logic                 out_last_o
);
  import obj_lex_pkg::*;

  logic [SlotW-1:0] cnt_q;
  logic [SlotW-1:0] idx_q;
  bundle_t          bnd_q;
  logic             pop;

  assign out_valid_o  = (cnt_q != '0);
  assign out_last_o   = (idx_q == cnt_q - 1'b1);
  assign out_kind_o   = bnd_q.kind[idx_q];
  assign out_start_o  = bnd_q.start[idx_q];
  assign out_length_o = bnd_q.length[idx_q];
  assign pop          = out_valid_o && out_ready_i;
  assign can_load_o   = !out_valid_o || (pop && out_last_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      cnt_q <= bundle_i.count;
      idx_q <= '0;
    end else if (pop) begin
      if (out_last_o) begin
        cnt_q <= '0;
        idx_q <= '0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bnd_q <= bundle_i;
    end
  end

endmodule

// File: hdl/obj_text_lexer_core.sv
// Mesh text lexer: splits an OBJ file into tokens, one text byte per beat.
// Slave side: tdata carries the character, tlast marks the final byte of a file.
// Master side: one beat per token; tuser holds the token kind, tdata holds
// the start offset (low 24 bits) and the length (next 24 bits), tlast marks
// the last token raised by a given input byte.
// A byte is taken into the input register, is lexed into a bundle of up
// to three tokens (closed word, slash, end of file), and that bundle is
// loaded into the bundle register, which drives the master side.
// Throughput: one byte per cycle while each byte raises at most one token and
// m_axis_tready stays high; a byte raising more holds the bundle register until
// all are taken. Bytes raising no token still pass while a bundle is stalled.
// An error token ends the stream: later bytes are dropped until a final byte
// re-arms the lexer. After an end token offsets restart from zero.
// Reset clears the mode, offsets and both valid flags; no beat is lost or
// repeated when the receiver deasserts tready, the bundle just holds and the
// input register fills, then s_axis_tready falls.
module obj_text_lexer_core #(
  parameter int OffsetBits = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // final_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [23:0] token_start, [47:24] token_length
  output logic [3:0]  m_axis_tuser,   // [3:0] token_kind
  output logic        m_axis_tlast    // run_end
);
  import obj_lex_pkg::*;

  bundle_t     bundle;
  logic        load;
  logic        can_load;
  logic [23:0] tok_start;
  logic [23:0] tok_length;

  // lexer state and input register
  obj_lex_scan #(
    .OffsetBits (OffsetBits)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_final_i (s_axis_tlast),
    .can_load_i (can_load),
    .load_o     (load),
    .bundle_o   (bundle)
  );

  // bundle register, drained one token per beat
  obj_lex_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .bundle_i     (bundle),
    .can_load_o   (can_load),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_kind_o   (m_axis_tuser),
    .out_start_o  (tok_start),
    .out_length_o (tok_length),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {tok_length, tok_start};

endmodule

// File: hdl/obj_lex_chk.sv
module obj_lex_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import obj_lex_pkg::*;

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("master valid dropped while stalled");

  a_hold_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("master beat changed while stalled");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_END |-> m_axis_tlast &&
      m_axis_tdata[47:24] == 24'd0)
    else $error("end token not last or with nonzero length");

  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_ERROR |-> m_axis_tlast)
    else $error("token follows an error");

  a_slash_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_SLASH |-> m_axis_tdata[47:24] == 24'd1)
    else $error("slash token length not one");

endmodule

bind obj_text_lexer_core obj_lex_chk u_chk (.*);

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import obj_lex_pkg::*;

  localparam int DirRows    = 26;
  localparam int RandBytes  = 400;
  localparam int HoldCycles = 300;
  localparam int IdleLimit  = 4000;
  localparam int TailCycles = 20;

  // One token beat: kind, start offset, length and the last-of-byte flag
  typedef struct packed {
    token_kind_e       kind;
    logic [FieldW-1:0] start;
    logic [FieldW-1:0] length;
    logic              last;
  } token_t;

  // Opening text: one character per row, with a hand-typed token where it is obvious
  typedef struct packed {
    logic [7:0]        ch;
    logic              fin;
    logic              typed;
    token_kind_e       kind;
    logic [FieldW-1:0] start;
    logic [FieldW-1:0] length;
  } text_row_t;

  localparam text_row_t OpeningText [DirRows] = '{
    '{CHAR_SLASH, 1'b0, 1'b1, KIND_SLASH, 24'd0, 24'd1},
    '{CHAR_V,     1'b0, 1'b0, KIND_END,   24'd0, 24'd0},
    '{8'h20,      1'b0, 1'b1, KIND_V,     24'd1, 24'd1},
    '{CHAR_V,     1'b0, 1'b0, KIND_END,   24'd0, 24'd0},
    '{CHAR_N,     1'b0, 1'b0, KIND_END,   24'd0, 24'd0},
    '{CHAR_SLASH, 1'b0, 1'b0, KIND_END,   24'd0, 24'd0},
    '{CHAR_V,     1'b0, 1'b0, KIND_END,   24'd0, 24'd0},
    '{CHAR_T,     1'b0, 1'b0, KIND_END,   24'd0, 24'd0},
    '{8'h09,      1'b0, 1'b0, KIND_END,   24'd0, 24'd0},
    '{CHAR_V,     1'b0, 1'b0, KIND_END,   24'd0, 24'd0},
    '{CHAR_P,     1'b0, 1'b0, KIND_END,   24'd0, 24'd0},
    '{8'h0A,      1'b0, 1'b0, KIND_END,   24'd0, 24'd0},
    '{CHAR_F,     1'b0, 1'b0, KIND_END,   24'd0, 24'd0},
    '{8'h0D,      1'b0, 1'b0, KIND_END,   24'd0, 24'd0},
    '{CHAR_O,     1'b0, 1'b0, KIND_END,   24'd0, 24'd0},
    '{8'h0B,      1'b0, 1'b0, KIND_END,   24'd0, 24'd0},
    '{CHAR_MINUS, 1'b0, 1'b0, KIND_END,   24'd0, 24'd0},
    '{8'h37,      1'b0, 1'b0, KIND_END,   24'd0, 24'd0},
    '{8'h0C,      1'b0, 1'b0, KIND_END,   24'd0, 24'd0},
    '{8'h5A,      1'b0, 1'b0, KIND_END,   24'd0, 24'd0},
    '{8'hFF,      1'b1, 1'b0, KIND_END,   24'd0, 24'd0},  // word closed by file end
    '{CHAR_MINUS, 1'b0, 1'b0, KIND_END,   24'd0, 24'd0},
    '{8'h20,      1'b0, 1'b1, KIND_ERROR, 24'd0, 24'd1},  // lone minus
    '{8'h61,      1'b0, 1'b0, KIND_END,   24'd0, 24'd0},  // stopped: dropped
    '{8'h00,      1'b1, 1'b0, KIND_END,   24'd0, 24'd0},  // final byte re-arms
    '{8'h23,      1'b1, 1'b1, KIND_ERROR, 24'd0, 24'd1}   // error on the final byte
  };

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data  = 8'h00;
  logic        s_last  = 1'b0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [47:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Lexer state as predicted from the accepted bytes
  lex_mode_e         lex_mode  = MODE_IDLE;
  logic [FieldW-1:0] next_pos  = '0;
  logic [FieldW-1:0] word_pos  = '0;
  logic [7:0]        lead_ch   = '0;
  logic [7:0]        second_ch = '0;

  token_t      tokens_due [$];
  logic [7:0]  file_text [$];
  int          bytes_in    = 0;
  int          live_bytes  = 0;
  int          files_sent  = 0;
  int          mismatches  = 0;
  int          idle_count  = 0;
  int          send_idle   = 0;
  int          recv_stall  = 0;
  int          hold_asks   = 0;
  int          hold_done   = 0;
  int          hold_left   = 0;
  int          kind_count [11];

  obj_text_lexer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic blank_ch(logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic digit_ch(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic letter_ch(logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic void rewind_lexer();
    lex_mode  = MODE_IDLE;
    next_pos  = '0;
    word_pos  = '0;
    lead_ch   = '0;
    second_ch = '0;
  endfunction

  function automatic token_kind_e word_kind(logic [FieldW-1:0] len);
    if (len == 1) begin
      if (lead_ch == CHAR_V) return KIND_V;
      if (lead_ch == CHAR_F) return KIND_F;
      if (lead_ch == CHAR_O) return KIND_O;
    end
    if (len == 2 && lead_ch == CHAR_V) begin
      if (second_ch == CHAR_N) return KIND_VN;
      if (second_ch == CHAR_T) return KIND_VT;
      if (second_ch == CHAR_P) return KIND_VP;
    end
    if (digit_ch(lead_ch)) return KIND_NUMBER;
    if (lead_ch == CHAR_MINUS && len > 1 && digit_ch(second_ch)) return KIND_NUMBER;
    if (letter_ch(lead_ch)) return KIND_IDENT;
    return KIND_ERROR;
  endfunction

  // Advance the predicted lexer by one byte; return the tokens it raises
  function automatic int lex_byte(input logic [7:0] ch, input logic fin, output token_t res [3]);
    int                n;
    logic              stop;
    logic [FieldW-1:0] len;
    token_kind_e       k;
    n    = 0;
    stop = 1'b0;
    res  = '{default: '0};
    if (lex_mode == MODE_STOP) begin
      if (fin) rewind_lexer();
      return 0;
    end
    if (lex_mode == MODE_WORD) begin
      len = next_pos - word_pos;
      if (blank_ch(ch) || ch == CHAR_SLASH) begin
        k        = word_kind(len);
        res[n]   = '{k, word_pos, len, 1'b0};
        n++;
        lex_mode = MODE_IDLE;
        stop     = (k == KIND_ERROR);
      end else if (len == 1) begin
        second_ch = ch;
      end
    end
    if (!stop && lex_mode == MODE_IDLE) begin
      if (ch == CHAR_SLASH) begin
        res[n] = '{KIND_SLASH, next_pos, 24'd1, 1'b0};
        n++;
      end else if (!blank_ch(ch)) begin
        lex_mode  = MODE_WORD;
        word_pos  = next_pos;
        lead_ch   = ch;
        second_ch = '0;
      end
    end
    next_pos = next_pos + 1'b1;
    if (!stop && fin) begin
      if (lex_mode == MODE_WORD) begin
        len    = next_pos - word_pos;
        k      = word_kind(len);
        res[n] = '{k, word_pos, len, 1'b0};
        n++;
        stop   = (k == KIND_ERROR);
      end
      if (!stop) begin
        res[n] = '{KIND_END, next_pos, 24'd0, 1'b0};
        n++;
      end
    end
    if (fin) rewind_lexer();
    else if (stop) lex_mode = MODE_STOP;
    if (n > 0) res[n-1].last = 1'b1;
    return n;
  endfunction

  // Predict on every accepted byte, check every accepted token, watch for a hang
  always @(posedge clk_i) begin
    token_t res [3];
    token_t got;
    token_t want;
    int     n;
    if (rst_ni) begin
      if (s_valid && s_axis_tready) begin
        if (lex_mode != MODE_STOP) live_bytes++;
        n = lex_byte(s_data, s_last, res);
        if (bytes_in < DirRows && OpeningText[bytes_in].typed) begin
          tokens_due.push_back('{OpeningText[bytes_in].kind, OpeningText[bytes_in].start,
                                 OpeningText[bytes_in].length, 1'b1});
        end else begin
          for (int i = 0; i < n; i++) tokens_due.push_back(res[i]);
        end
        bytes_in++;
      end
      if (m_axis_tvalid && m_ready) begin
        got = '{token_kind_e'(m_axis_tuser), m_axis_tdata[23:0], m_axis_tdata[47:24],
                m_axis_tlast};
        if (m_axis_tuser <= KIND_END) kind_count[m_axis_tuser]++;
        if (tokens_due.size() == 0) begin
          $error("unexpected token beat: kind %0d start %0d length %0d",
                 m_axis_tuser, got.start, got.length);
          mismatches++;
        end else begin
          want = tokens_due.pop_front();
          if (got.kind !== want.kind) begin
            $error("token_kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
            mismatches++;
          end
          if (got.start !== want.start) begin
            $error("token_start: expected %0d, actual %0d", want.start, got.start);
            mismatches++;
          end
          if (got.length !== want.length) begin
            $error("token_length: expected %0d, actual %0d", want.length, got.length);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $error("run_end: expected %0d, actual %0d", want.last, got.last);
            mismatches++;
          end
        end
      end
      if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
        idle_count = 0;
      end else begin
        idle_count++;
        if (idle_count >= IdleLimit) begin
          $display("Timeout: no beat for %0d cycles", IdleLimit);
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is asked for
  always @(negedge clk_i) begin
    if (hold_asks != hold_done) begin
      hold_done = hold_asks;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      m_ready = 1'b0;
      hold_left--;
    end else begin
      m_ready = ($urandom_range(99) >= recv_stall);
    end
  end

  // Offer one byte, idling at random first; return at the falling edge after acceptance
  task automatic send_char(input logic [7:0] ch, input logic fin);
    while ($urandom_range(99) < send_idle) begin
      s_valid = 1'b0;
      @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_data  = ch;
    s_last  = fin;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic void push_blank();
    logic [7:0] blanks [6];
    blanks = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    file_text.push_back(blanks[$urandom_range(5)]);
  endfunction

  function automatic void push_digits();
    repeat ($urandom_range(1, 4)) file_text.push_back(8'h30 + 8'($urandom_range(9)));
  endfunction

  function automatic void push_number();
    if ($urandom_range(2) == 0) file_text.push_back(CHAR_MINUS);
    push_digits();
    if ($urandom_range(1) == 0) begin
      file_text.push_back(8'h2E);
      push_digits();
    end
  endfunction

  function automatic void push_keyword();
    int pick;
    pick = $urandom_range(7);
    case (pick)
      0: file_text.push_back(CHAR_F);
      1: file_text.push_back(CHAR_O);
      default: begin
        file_text.push_back(CHAR_V);
        case (pick)
          3: file_text.push_back(CHAR_N);
          4: file_text.push_back(CHAR_T);
          5: file_text.push_back(CHAR_P);
          6: file_text.push_back(8'h78);  // near miss: two letters, no keyword
          default: ;
        endcase
      end
    endcase
  endfunction

  function automatic void push_ident();
    logic [7:0] c;
    c = 8'($urandom_range(25));
    file_text.push_back(($urandom_range(1) == 0) ? 8'h41 + c : 8'h61 + c);
    repeat ($urandom_range(5)) begin
      if ($urandom_range(9) < 7) begin
        c = 8'h61 + 8'($urandom_range(25));
      end else begin
        // any byte that cannot end the word, the top half included
        do c = 8'($urandom_range(8'h0E, 8'hFF)); while (c == 8'h20 || c == CHAR_SLASH);
      end
      file_text.push_back(c);
    end
  endfunction

  // Face corner: index, or index/index/index, or index//index
  function automatic void push_corner();
    push_digits();
    if ($urandom_range(1) == 0) begin
      file_text.push_back(CHAR_SLASH);
      if ($urandom_range(2) != 0) push_digits();
      file_text.push_back(CHAR_SLASH);
      push_digits();
    end
  endfunction

  function automatic void build_file();
    int words;
    int r;
    file_text.delete();
    words = $urandom_range(1, 10);
    for (int w = 0; w < words; w++) begin
      r = $urandom_range(99);
      if (r < 25)      push_keyword();
      else if (r < 45) push_number();
      else if (r < 62) push_corner();
      else if (r < 77) push_ident();
      else if (r < 87) file_text.push_back(CHAR_SLASH);
      else if (r < 95) push_blank();
      else             file_text.push_back(8'($urandom_range(255)));  // noise
      // words mostly apart; the last one often runs into the file end
      if ($urandom_range(99) < ((w == words - 1) ? 50 : 90)) push_blank();
    end
  endfunction

  initial begin
    int send_pct [4];
    int recv_pct [4];
    int goal;
    send_pct = '{0, 48, 0, 22};
    recv_pct = '{0, 0, 48, 22};
    for (int k = 0; k < 11; k++) kind_count[k] = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed opening text, no idling
    for (int i = 0; i < DirRows; i++) send_char(OpeningText[i].ch, OpeningText[i].fin);

    // Random files across the idling phases
    for (int p = 0; p < 4; p++) begin
      send_idle  = send_pct[p];
      recv_stall = recv_pct[p];
      // fill the block against a held-off receiver
      if (p == 0 || p == 2) hold_asks++;
      goal = live_bytes + RandBytes / 4;
      while (live_bytes < goal) begin
        build_file();
        for (int i = 0; i < file_text.size(); i++) begin
          send_char(file_text[i], i == file_text.size() - 1);
        end
        files_sent++;
      end
    end
    s_valid = 1'b0;
    s_last  = 1'b0;

    // Drain; the watchdog bounds this wait
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d bytes (%0d lexed) in %0d random files plus the opening text",
             bytes_in, live_bytes, files_sent);
    $display("Tokens: %0d keyword, %0d number, %0d ident, %0d slash, %0d error, %0d end",
             kind_count[KIND_V] + kind_count[KIND_VN] + kind_count[KIND_VT] +
             kind_count[KIND_VP] + kind_count[KIND_F] + kind_count[KIND_O],
             kind_count[KIND_NUMBER], kind_count[KIND_IDENT], kind_count[KIND_SLASH],
             kind_count[KIND_ERROR], kind_count[KIND_END]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
